>>> src/pars_pkg.sv
`default_nettype none

package pars_pkg;

   // Default geometry of the array.
   localparam int MAX_SEGMENTS_DEF      = 64;
   localparam int MAX_SEGMENT_SLOTS_DEF = 64;

   // Fixed field widths.
   localparam int KEY_W        = 64;
   localparam int SLOT_IDX_W   = 12;
   localparam int SEG_IDX_W    = 6;
   localparam int FILL_W       = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 7;

   // Operation codes.
   localparam logic [1:0] OP_WRITE_SLOT = 2'd0;
   localparam logic [1:0] OP_WRITE_FILL = 2'd1;
   localparam logic [1:0] OP_OPEN_SCAN  = 2'd2;
   localparam logic [1:0] OP_NEXT_PAIR  = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ORDER = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENTS_IN_USE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_PER_SEGMENT = 1'b1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] SEGMENTS_RESET = 7'd64;
   localparam logic [CSR_DATA_W-1:0] SLOTS_RESET    = 7'd64;

   typedef struct packed {
      logic [1:0]              operation;
      logic [SLOT_IDX_W-1:0]   slot_index;
      logic signed [KEY_W-1:0] entry_key;
      logic signed [KEY_W-1:0] entry_value;
      logic [SEG_IDX_W-1:0]    segment_index;
      logic [FILL_W-1:0]       segment_fill;
      logic [SEG_IDX_W-1:0]    segment_first;
      logic [SEG_IDX_W-1:0]    segment_last;
      logic signed [KEY_W-1:0] key_low;
      logic signed [KEY_W-1:0] key_high;
   } req_type;

   typedef struct packed {
      logic                    pair_valid;
      logic signed [KEY_W-1:0] out_key;
      logic signed [KEY_W-1:0] out_value;
      logic                    has_more;
      logic [1:0]              status;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/pars_ram.sv
`default_nettype none

module pars_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/packed_array_range_scan_unit.sv
`default_nettype none

// Range-scan engine over a segmented sorted array held in one key/value memory
// (MAX_SEGMENTS * MAX_SEGMENT_SLOTS entries) and one small fill-count memory.
// Even segments keep their keys right-aligned and odd segments left-aligned, so
// each even/odd pair is one contiguous run. Every request produces exactly one
// response. An open-scan request walks the stored keys, first forward from
// segment_first until the first key at or above key_low, then backward from
// segment_last until the last key at or below key_high. A next request that
// finishes a run also moves the engine on to the following run, if a segment
// remains. The key/value memory has a single read port with registered read
// data; each examined slot is one read and one compare. A new request is taken
// once the engine is idle, even while the previous response is still held in
// the output register. The segment and slot registers may be written only while
// the engine is idle; a scan in progress continues with the new geometry. Fill
// counts read as zero after reset; key and value slots hold no defined contents
// until they are written.
module packed_array_range_scan_unit import pars_pkg::*; #(
   parameter int MAX_SEGMENTS      = MAX_SEGMENTS_DEF,
   parameter int MAX_SEGMENT_SLOTS = MAX_SEGMENT_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH   = MAX_SEGMENTS * MAX_SEGMENT_SLOTS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int POS_W   = $clog2(DEPTH + 1);
   localparam int SEG_W   = $clog2(MAX_SEGMENTS);
   localparam int SEGC_W  = $clog2(MAX_SEGMENTS + 2);
   localparam int SLOTN_W = $clog2(MAX_SEGMENT_SLOTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F_FILL,
      ST_F_BOUND,
      ST_F_ADDR,
      ST_F_CMP,
      ST_F_PAIR,
      ST_B_FILL,
      ST_B_BOUND,
      ST_B_ADDR,
      ST_B_CMP,
      ST_N_DATA,
      ST_N_ADV,
      ST_N_ADV2,
      ST_N_ADV3,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // Geometry registers.
   logic [CSR_DATA_W-1:0] segments_ff;
   logic [CSR_DATA_W-1:0] slots_ff;

   // Scan state that lives between requests.
   logic [POS_W-1:0]  cursor_ff;
   logic [POS_W-1:0]  run_end_ff;
   logic [POS_W-1:0]  limit_ff;
   logic [SEGC_W-1:0] nextseg_ff;

   // Working registers of an open scan.
   logic [SEGC_W-1:0]       seg_ff;
   logic [SEGC_W-1:0]       s2_ff;
   logic [SEG_IDX_W-1:0]    last_ff;
   logic signed [KEY_W-1:0] klo_ff;
   logic signed [KEY_W-1:0] khi_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        start_ff;
   logic [POS_W-1:0]        stop_ff;

   // Response staging and output register.
   rsp_type res_ff;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;

   // Fill-count valid bits, cleared by reset.
   logic [MAX_SEGMENTS-1:0] fill_vld_ff;
   logic                    fill_vld_rd_ff;

   logic                    req_accept;
   logic                    emit_load;
   logic [1:0]              idle_status;
   logic                    pair_we;
   logic                    fill_we;
   logic [ADDR_W-1:0]       pair_raddr;
   logic [SEG_W-1:0]        fill_raddr;
   logic [2*KEY_W-1:0]      pair_q;
   logic [FILL_W-1:0]       fill_q;
   logic signed [KEY_W-1:0] key_q;
   logic signed [KEY_W-1:0] value_q;
   logic [FILL_W-1:0]       fill_raw;
   logic [SLOTN_W-1:0]      fill_eff;
   logic [SEGC_W-1:0]       nseg;
   logic [SLOTN_W-1:0]      cap;
   logic [SEGC_W-1:0]       seg_sel;
   logic [POS_W-1:0]        base;
   logic [POS_W-1:0]        bound_start;
   logic [POS_W-1:0]        bound_stop;
   logic [POS_W-1:0]        cursor_inc;
   logic [POS_W-1:0]        b_run;
   logic [POS_W-1:0]        adv_run;
   logic [POS_W-1:0]        adv3_sum;
   logic [POS_W-1:0]        adv3_run;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The finished response moves to the output register once it is free.
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Registers above the supported maximum are clamped.
   assign nseg = (32'(segments_ff) > MAX_SEGMENTS) ? SEGC_W'(MAX_SEGMENTS)
                                                   : SEGC_W'(segments_ff);
   assign cap  = (32'(slots_ff) > MAX_SEGMENT_SLOTS) ? SLOTN_W'(MAX_SEGMENT_SLOTS)
                                                     : SLOTN_W'(slots_ff);

   // A fill count that was never written reads as zero; a count above the
   // segment capacity is used as the capacity.
   assign fill_raw = fill_vld_rd_ff ? fill_q : '0;
   assign fill_eff = (32'(fill_raw) > 32'(cap)) ? cap : SLOTN_W'(fill_raw);

   assign key_q   = $signed(pair_q[2*KEY_W-1:KEY_W]);
   assign value_q = $signed(pair_q[KEY_W-1:0]);

   assign pair_we = req_accept && (req_data.operation == OP_WRITE_SLOT) &&
                    (32'(req_data.slot_index) < DEPTH);
   assign fill_we = req_accept && (req_data.operation == OP_WRITE_FILL) &&
                    (32'(req_data.segment_index) < MAX_SEGMENTS);

   // Status of a request that is settled at acceptance.
   always_comb begin
      priority if (req_data.operation == OP_OPEN_SCAN &&
                   req_data.segment_first > req_data.segment_last) begin
         idle_status = STATUS_ORDER;
      end else if (req_data.operation == OP_NEXT_PAIR &&
                   !(cursor_ff < run_end_ff && 32'(cursor_ff) < DEPTH)) begin
         idle_status = STATUS_EMPTY;
      end else begin
         idle_status = STATUS_OK;
      end
   end

   // In idle the memory already reads the slot under the cursor, so a next
   // request finds its pair in the cycle after it is taken.
   always_comb begin
      priority if (state_ff == ST_IDLE) begin
         pair_raddr = ADDR_W'(cursor_ff);
      end else if (state_ff == ST_B_ADDR) begin
         pair_raddr = ADDR_W'(pos_ff - 1'b1);
      end else begin
         pair_raddr = ADDR_W'(pos_ff);
      end
   end

   // The fill-count memory is read in the state before the one that uses it.
   always_comb begin
      unique case (state_ff)
         ST_F_CMP:  fill_raddr = SEG_W'(seg_ff + 1'b1);
         ST_B_FILL: fill_raddr = SEG_W'(s2_ff);
         ST_N_ADV:  fill_raddr = SEG_W'(nextseg_ff);
         ST_N_ADV2: fill_raddr = SEG_W'(nextseg_ff + 1'b1);
         default:   fill_raddr = SEG_W'(seg_ff);
      endcase
   end

   // Slot bounds of one segment: the occupied slots are [start, stop).
   always_comb begin
      unique case (state_ff)
         ST_B_BOUND: seg_sel = s2_ff;
         ST_N_ADV2:  seg_sel = nextseg_ff;
         default:    seg_sel = seg_ff;
      endcase
   end

   assign base = POS_W'(seg_sel) * POS_W'(cap);

   always_comb begin
      if (seg_sel[0]) begin
         bound_start = base;
         bound_stop  = base + POS_W'(fill_eff);
      end else begin
         bound_stop  = base + POS_W'(cap);
         bound_start = bound_stop - POS_W'(fill_eff);
      end
   end

   assign cursor_inc = cursor_ff + 1'b1;
   assign b_run      = (pos_ff < run_end_ff) ? pos_ff : run_end_ff;
   assign adv_run    = (bound_stop < limit_ff) ? bound_stop : limit_ff;
   assign adv3_sum   = stop_ff + POS_W'(fill_eff);
   assign adv3_run   = (adv3_sum < limit_ff) ? adv3_sum : limit_ff;

   pars_ram #(
      .WIDTH (2 * KEY_W),
      .DEPTH (DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_we),
      .wr_addr (ADDR_W'(req_data.slot_index)),
      .wr_data ({req_data.entry_key, req_data.entry_value}),
      .rd_addr (pair_raddr),
      .rd_data (pair_q)
   );

   pars_ram #(
      .WIDTH (FILL_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (SEG_W'(req_data.segment_index)),
      .wr_data (req_data.segment_fill),
      .rd_addr (fill_raddr),
      .rd_data (fill_q)
   );

   always_ff @(posedge clock) begin
      fill_vld_rd_ff <= fill_vld_ff[fill_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (fill_we) begin
         fill_vld_ff[SEG_W'(req_data.segment_index)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEGMENTS_RESET;
         slots_ff    <= SLOTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEGMENTS_IN_USE:   segments_ff <= csr_wdata;
            CSR_SLOTS_PER_SEGMENT: slots_ff    <= csr_wdata;
            default:               ;
         endcase
      end
   end

   // Payload-only working registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            last_ff  <= req_data.segment_last;
            klo_ff   <= req_data.key_low;
            khi_ff   <= req_data.key_high;
            seg_ff   <= SEGC_W'(req_data.segment_first);
            res_ff   <= '{pair_valid: 1'b0, out_key: '0, out_value: '0,
                          has_more: 1'b0, status: idle_status};
         end
         ST_F_BOUND, ST_B_BOUND: begin
            start_ff <= bound_start;
            stop_ff  <= bound_stop;
            pos_ff   <= (state_ff == ST_F_BOUND) ? bound_start : bound_stop;
         end
         ST_F_ADDR: begin
            if (!(pos_ff < stop_ff)) begin
               seg_ff <= seg_ff + 1'b1;
            end
         end
         ST_F_CMP: begin
            pos_ff <= pos_ff + 1'b1;
            s2_ff  <= SEGC_W'(last_ff);
         end
         ST_F_PAIR: begin
            s2_ff <= SEGC_W'(last_ff);
         end
         ST_B_ADDR: begin
            if (!(pos_ff > start_ff)) begin
               s2_ff <= s2_ff - 1'b1;
            end
         end
         ST_B_CMP: begin
            pos_ff <= pos_ff - 1'b1;
            res_ff.has_more <= (cursor_ff < b_run);
         end
         ST_N_DATA: begin
            res_ff.pair_valid <= 1'b1;
            res_ff.out_key    <= key_q;
            res_ff.out_value  <= value_q;
            res_ff.has_more   <= (cursor_inc < run_end_ff);
         end
         ST_N_ADV2: begin
            stop_ff         <= bound_stop;
            res_ff.has_more <= (bound_start < adv_run);
         end
         ST_N_ADV3: begin
            res_ff.has_more <= (cursor_ff < adv3_run);
         end
         default: ;
      endcase
   end

   // Control state, scan state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         run_end_ff   <= '0;
         limit_ff     <= '0;
         nextseg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  unique case (req_data.operation)
                     OP_OPEN_SCAN: begin
                        // Every open scan starts from an empty scan.
                        cursor_ff  <= '0;
                        run_end_ff <= '0;
                        limit_ff   <= '0;
                        nextseg_ff <= '0;
                        if (req_data.segment_first <= req_data.segment_last &&
                            req_data.segment_last < nseg) begin
                           state_ff <= ST_F_FILL;
                        end else begin
                           state_ff <= ST_EMIT;
                        end
                     end
                     OP_NEXT_PAIR: begin
                        if (cursor_ff < run_end_ff && 32'(cursor_ff) < DEPTH) begin
                           state_ff <= ST_N_DATA;
                        end else begin
                           state_ff <= ST_EMIT;
                        end
                     end
                     default: begin
                        state_ff <= ST_EMIT;
                     end
                  endcase
               end
            end
            ST_F_FILL: begin
               // A first match past the last segment gives an empty scan.
               if (seg_ff >= nseg || seg_ff > SEGC_W'(last_ff)) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_F_BOUND;
               end
            end
            ST_F_BOUND: begin
               state_ff <= ST_F_ADDR;
            end
            ST_F_ADDR: begin
               state_ff <= (pos_ff < stop_ff) ? ST_F_CMP : ST_F_FILL;
            end
            ST_F_CMP: begin
               if (key_q < klo_ff) begin
                  state_ff <= ST_F_ADDR;
               end else if (key_q > khi_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  cursor_ff  <= pos_ff;
                  run_end_ff <= stop_ff;
                  nextseg_ff <= seg_ff + 1'b1;
                  if (!seg_ff[0] && (seg_ff + 1'b1) < nseg) begin
                     state_ff <= ST_F_PAIR;
                  end else begin
                     state_ff <= ST_B_FILL;
                  end
               end
            end
            ST_F_PAIR: begin
               // The odd partner continues the run of an even segment.
               run_end_ff <= stop_ff + POS_W'(fill_eff);
               nextseg_ff <= seg_ff + 2'd2;
               state_ff   <= ST_B_FILL;
            end
            ST_B_FILL: begin
               state_ff <= ST_B_BOUND;
            end
            ST_B_BOUND: begin
               state_ff <= ST_B_ADDR;
            end
            ST_B_ADDR: begin
               if (pos_ff > start_ff) begin
                  state_ff <= ST_B_CMP;
               end else if (s2_ff == seg_ff) begin
                  cursor_ff  <= '0;
                  run_end_ff <= '0;
                  nextseg_ff <= '0;
                  state_ff   <= ST_EMIT;
               end else begin
                  state_ff <= ST_B_FILL;
               end
            end
            ST_B_CMP: begin
               if (key_q > khi_ff) begin
                  state_ff <= ST_B_ADDR;
               end else begin
                  if (pos_ff <= cursor_ff) begin
                     // The last match lies before the first one.
                     cursor_ff  <= '0;
                     run_end_ff <= '0;
                     nextseg_ff <= '0;
                  end else begin
                     limit_ff   <= pos_ff;
                     run_end_ff <= b_run;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_N_DATA: begin
               cursor_ff <= cursor_inc;
               if (cursor_inc >= run_end_ff && nextseg_ff < nseg) begin
                  state_ff <= ST_N_ADV;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_N_ADV: begin
               state_ff <= ST_N_ADV2;
            end
            ST_N_ADV2: begin
               cursor_ff <= bound_start;
               if (!nextseg_ff[0] && (nextseg_ff + 1'b1) < nseg) begin
                  state_ff <= ST_N_ADV3;
               end else begin
                  run_end_ff <= adv_run;
                  nextseg_ff <= nextseg_ff + (nextseg_ff[0] ? 2'd1 : 2'd2);
                  state_ff   <= ST_EMIT;
               end
            end
            ST_N_ADV3: begin
               run_end_ff <= adv3_run;
               nextseg_ff <= nextseg_ff + 2'd2;
               state_ff   <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_data_ff <= res_ff;
      end
   end

`ifndef SYNTH
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response loaded outside the emit state");

   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pair_valid |-> rsp_data_ff.status == STATUS_OK)
      else $error("returned pair carries an error status");

   a_error_no_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != STATUS_OK |-> !rsp_data_ff.has_more)
      else $error("error response claims more pairs");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the packed array range-scan unit.
// A scoreboard in this module tracks the key/value slots, the fill counts, the
// geometry registers and the open scan. Each request is predicted when it is
// issued and the predicted response is queued once the block accepts it. A
// checker compares every response against the oldest queued prediction.
// Slots that were never written must never be read. So every scan or next
// request is first tried against the scoreboard. If it would touch such a
// slot, the scan state is restored and the request is dropped.
module tb;
   import pars_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int NUM_SEGS    = 64;
   localparam int IDLE_LIMIT  = 40000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   packed_array_range_scan_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Scoreboard copy of the array and of the open scan.
   logic [63:0] key_mem [STORE_DEPTH];
   logic [63:0] val_mem [STORE_DEPTH];
   bit          slot_written [STORE_DEPTH];
   int          fill_mem [NUM_SEGS];
   int          scan_pos, run_stop, scan_stop, seg_after;
   int          seg_cfg = 64, slot_cfg = 64;
   bit          touched_unwritten;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      issued = 0;
   bit      tx_gaps = 1'b1, rx_stalls = 1'b1, hold_request = 1'b0;

   // Phase key layout: keys rise with the slot index, so any fill pattern
   // still leaves every run sorted.
   logic signed [63:0] key_base, key_stride;

   function automatic int seg_count();
      return seg_cfg > NUM_SEGS ? NUM_SEGS : seg_cfg;
   endfunction

   function automatic int seg_cap();
      return slot_cfg > 64 ? 64 : slot_cfg;
   endfunction

   function automatic int seg_fill(int s);
      int c;
      c = seg_cap();
      if (s < 0 || s >= NUM_SEGS) return 0;
      return fill_mem[s] > c ? c : fill_mem[s];
   endfunction

   function automatic logic signed [63:0] key_read(int i);
      if (i < 0 || i >= STORE_DEPTH) return 64'sd0;
      if (!slot_written[i]) touched_unwritten = 1'b1;
      return key_mem[i];
   endfunction

   function automatic void clear_scan();
      scan_pos = 0; run_stop = 0; scan_stop = 0; seg_after = 0;
   endfunction

   function automatic void open_scan(int first, int last,
                                     logic signed [63:0] klo, logic signed [63:0] khi);
      int n, c, seg, start, stop, off, s2, hi, lo, o;
      bit found;
      n = seg_count(); c = seg_cap();
      seg = first; start = 0; stop = 0; off = 0; found = 0;
      clear_scan();
      if (last >= n) return;
      // Forward search for the first key at or above the lower bound.
      while (seg < n) begin
         if (seg % 2 == 0) begin
            stop = (seg + 1) * c;
            start = stop - seg_fill(seg);
         end else begin
            start = seg * c;
            stop = start + seg_fill(seg);
         end
         off = start;
         while (off < stop && key_read(off) < klo) off++;
         if (off < stop) begin
            found = 1;
            break;
         end
         seg++;
      end
      if (!found || seg > last) return;
      if (key_read(off) > khi) return;
      scan_pos = off;
      seg_after = seg + 1;
      run_stop = stop;
      if (seg % 2 == 0 && seg + 1 < n) begin
         run_stop = (seg + 1) * c + seg_fill(seg + 1);
         seg_after++;
      end
      // Backward search for the last key at or below the upper bound.
      found = 0;
      for (s2 = last; s2 >= seg; s2--) begin
         if (s2 % 2 == 0) begin
            hi = (s2 + 1) * c - 1;
            lo = hi - seg_fill(s2);
            o = hi;
            while (o > lo && key_read(o) > khi) o--;
            if (o > lo) begin
               found = 1; off = o;
               break;
            end
         end else begin
            lo = s2 * c;
            hi = lo + seg_fill(s2) - 1;
            o = hi;
            while (o >= lo && key_read(o) > khi) o--;
            if (o >= lo) begin
               found = 1; off = o;
               break;
            end
         end
      end
      if (!found || off < scan_pos) begin
         clear_scan();
         return;
      end
      scan_stop = off + 1;
      if (scan_stop < run_stop) run_stop = scan_stop;
   endfunction

   function automatic void advance_run();
      int n, c, s, stop;
      n = seg_count(); c = seg_cap(); s = seg_after;
      if (s >= n) return;
      if (s % 2 == 0) begin
         stop = (s + 1) * c;
         scan_pos = s * c + c - seg_fill(s);
         if (s + 1 < n) run_stop = stop + seg_fill(s + 1);
         else run_stop = stop;
         if (scan_stop < run_stop) run_stop = scan_stop;
         seg_after += 2;
      end else begin
         scan_pos = s * c;
         run_stop = scan_pos + seg_fill(s);
         if (scan_stop < run_stop) run_stop = scan_stop;
         seg_after++;
      end
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type e;
      e = '0;
      case (r.operation)
         OP_WRITE_SLOT: begin
            key_mem[r.slot_index] = r.entry_key;
            val_mem[r.slot_index] = r.entry_value;
            slot_written[r.slot_index] = 1'b1;
         end
         OP_WRITE_FILL: fill_mem[r.segment_index] = int'(r.segment_fill);
         OP_OPEN_SCAN: begin
            if (r.segment_first > r.segment_last) begin
               clear_scan();
               e.status = STATUS_ORDER;
            end else begin
               open_scan(int'(r.segment_first), int'(r.segment_last),
                         r.key_low, r.key_high);
            end
            e.has_more = scan_pos < run_stop;
         end
         default: begin
            if (scan_pos < run_stop && scan_pos < STORE_DEPTH) begin
               if (!slot_written[scan_pos]) touched_unwritten = 1'b1;
               e.pair_valid = 1'b1;
               e.out_key = key_mem[scan_pos];
               e.out_value = val_mem[scan_pos];
               scan_pos++;
               if (scan_pos >= run_stop) advance_run();
               e.has_more = scan_pos < run_stop;
            end else begin
               e.status = STATUS_EMPTY;
            end
         end
      endcase
      return e;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type random_request();
      req_type r;
      r = $bits(req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom});
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $time);
      errors++;
   endtask

   // Sends one request, called at a falling edge. A scan or next request that
   // would read an unwritten slot is dropped before it reaches the block.
   task automatic send_request(req_type r);
      rsp_type e;
      int p, rs, ss, sa, gap;
      p = scan_pos; rs = run_stop; ss = scan_stop; sa = seg_after;
      touched_unwritten = 1'b0;
      e = predict_response(r);
      if (touched_unwritten) begin
         scan_pos = p; run_stop = rs; scan_stop = ss; seg_after = sa;
         req_valid = 1'b0;
         @(negedge clock);
         return;
      end
      req_data = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(e);
      issued++;
      @(negedge clock);
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_slot(int slot, logic [63:0] k);
      req_type r;
      r = random_request();
      r.operation = OP_WRITE_SLOT;
      r.slot_index = SLOT_IDX_W'(slot);
      r.entry_key = k;
      send_request(r);
   endtask

   task automatic write_fill(int seg, int f);
      req_type r;
      r = random_request();
      r.operation = OP_WRITE_FILL;
      r.segment_index = SEG_IDX_W'(seg);
      r.segment_fill = FILL_W'(f);
      send_request(r);
   endtask

   task automatic scan_request(int first, int last, logic [63:0] klo, logic [63:0] khi);
      req_type r;
      r = random_request();
      r.operation = OP_OPEN_SCAN;
      r.segment_first = SEG_IDX_W'(first);
      r.segment_last = SEG_IDX_W'(last);
      r.key_low = klo;
      r.key_high = khi;
      send_request(r);
   endtask

   task automatic next_request();
      req_type r;
      r = random_request();
      r.operation = OP_NEXT_PAIR;
      send_request(r);
   endtask

   // Waits at a falling edge until every predicted response has arrived.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register writes happen only with the engine idle.
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, int value);
      wait_drained();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      if (idx == CSR_SEGMENTS_IN_USE) seg_cfg = value;
      else slot_cfg = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Four segments of two slots. Keys span the signed extremes, one run
   // half is empty, and one fill count exceeds the segment capacity.
   task automatic test_directed();
      logic [63:0] k;
      next_request();          // next with no scan open
      write_register(CSR_SEGMENTS_IN_USE, 4);
      write_register(CSR_SLOTS_PER_SEGMENT, 2);
      for (int i = 0; i < 8; i++) begin
         if (i == 0) k = 64'h8000_0000_0000_0000;
         else if (i == 7) k = 64'h7fff_ffff_ffff_ffff;
         else k = 64'(i * 1000 - 3000);
         write_slot(i, k);
      end
      write_fill(0, 2);
      write_fill(1, 1);
      write_fill(2, 0);
      write_fill(3, 100);
      scan_request(0, 3, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
      repeat (6) next_request();
      scan_request(3, 1, 0, 0);          // first segment after last
      scan_request(0, 5, 0, 0);          // last segment beyond those in use
      scan_request(0, 0, 64'd5000, 64'h7fff_ffff_ffff_ffff); // match past last
      scan_request(1, 3, -64'sd2000, 64'd3500);
      next_request();
   endtask

   function automatic logic [63:0] phase_key(int slot);
      return key_base + slot * key_stride + (rand64() & (key_stride - 1));
   endfunction

   // Loads the first segments of the current geometry with sorted keys.
   task automatic load_array();
      int n, c, segs, f, lo;
      n = seg_count(); c = seg_cap();
      key_stride = 64'sd1 << $urandom_range(4, 48);
      key_base = -(64'sd1 << 60) + $signed(rand64() >> 4);
      for (int s = 0; s < 8; s++) if (fill_mem[s] != 0) write_fill(s, 0);
      segs = c > 8 ? 4 : 8;
      if (segs > n) segs = n;
      for (int s = 0; s < segs; s++) begin
         f = $urandom_range(0, c > 8 ? 6 : c);
         if (c <= 8 && $urandom_range(0, 7) == 0) f = $urandom_range(c, 127);
         lo = (s % 2 == 0) ? (s + 1) * c - (f > c ? c : f) : s * c;
         for (int i = 0; i < (f > c ? c : f); i++) write_slot(lo + i, phase_key(lo + i));
         write_fill(s, f);
      end
   endtask

   // Mostly well-formed scans followed by a burst of next requests, with
   // some malformed scans, stray writes and lone next requests mixed in.
   task automatic scan_traffic(int count);
      int stop_at, n, slots, first, last, a, b, roll;
      req_type r;
      stop_at = issued + count;
      n = seg_count();
      slots = (n > 8 ? 8 : n) * seg_cap();
      while (issued < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 75 && n > 0) begin
            first = $urandom_range(0, n - 1);
            last = $urandom_range(first, n - 1);
            a = $urandom_range(0, slots);
            b = $urandom_range(0, slots);
            if ($urandom_range(0, 4) != 0 && b < a) begin
               int t;
               t = a; a = b; b = t;
            end
            scan_request(first, last, key_base + a * key_stride,
                         key_base + b * key_stride + (rand64() & (key_stride - 1)));
            repeat ($urandom_range(0, 8)) next_request();
         end else if (roll < 82) begin
            r = random_request();
            send_request(r);
         end else if (roll < 88) begin
            a = $urandom_range(0, 63);
            write_fill(a, a < 8 ? $urandom_range(0, 127) : 0);
         end else if (roll < 94) begin
            write_slot($urandom_range(0, STORE_DEPTH - 1), rand64());
         end else if (roll < 97) begin
            next_request();
         end else begin
            wait_drained();    // sender pauses until the block is empty
         end
      end
   endtask

   // Walks several geometries, including the register extremes.
   task automatic test_geometry_sweep();
      int geo [13][2] = '{'{4, 4}, '{8, 2}, '{1, 1}, '{2, 8}, '{127, 127}, '{0, 3},
                          '{64, 64}, '{3, 5}, '{8, 8}, '{6, 1}, '{64, 1}, '{5, 0},
                          '{1, 64}};
      for (int g = 0; g < 13; g++) begin
         tx_gaps = (g % 4 != 1);
         rx_stalls = (g % 4 != 2);
         write_register(CSR_SEGMENTS_IN_USE, geo[g][0]);
         write_register(CSR_SLOTS_PER_SEGMENT, geo[g][1]);
         load_array();
         scan_traffic(70);
      end
      tx_gaps = 1'b1;
      rx_stalls = 1'b1;
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block backs up and stalls its input.
   task automatic test_backpressure();
      write_register(CSR_SEGMENTS_IN_USE, 8);
      write_register(CSR_SLOTS_PER_SEGMENT, 4);
      load_array();
      tx_gaps = 1'b0;
      hold_request = 1'b1;
      scan_traffic(40);
      tx_gaps = 1'b1;
      scan_traffic(120);
   endtask

   // Receiver stall generator, with a long hold-off on request.
   int stall_left = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rx_stalls) stall_left = pick_gap();
      end
   end

   // Response checker.
   always @(posedge clock) begin : check_responses
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report("response with nothing pending", rsp_data.out_key, 64'd0);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.pair_valid !== e.pair_valid)
               report("pair_valid", 64'(rsp_data.pair_valid), 64'(e.pair_valid));
            if (rsp_data.out_key !== e.out_key)
               report("out_key", rsp_data.out_key, e.out_key);
            if (rsp_data.out_value !== e.out_value)
               report("out_value", rsp_data.out_value, e.out_value);
            if (rsp_data.has_more !== e.has_more)
               report("has_more", 64'(rsp_data.has_more), 64'(e.has_more));
            if (rsp_data.status !== e.status)
               report("status", 64'(rsp_data.status), 64'(e.status));
         end
      end
   end

   // Watchdog: too many cycles with no handshake on any port ends the run.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < NUM_SEGS; s++) fill_mem[s] = 0;
      for (int i = 0; i < STORE_DEPTH; i++) slot_written[i] = 1'b0;
      clear_scan();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_geometry_sweep();
      test_backpressure();
      wait_drained();
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
